// ===== rtl/core/twpg_pkg.sv =====
package twpg_pkg;

    localparam int TASK_COUNT = 8;
    localparam int TASK_W     = 5;
    localparam int FAIL_W     = 6;
    localparam int CNT_W      = 32;

    typedef logic [TASK_COUNT-1:0] t_mask;

    localparam t_mask MASK_RESET = t_mask'(3);
    localparam logic [FAIL_W-1:0] FAIL_NONE = FAIL_W'(TASK_COUNT);

    typedef enum logic [2:0] {
        CMD_MARK    = 3'd0,
        CMD_CYCLE   = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_REQUIRE = 3'd3,
        CMD_FORCE   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FAULT = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [TASK_W-1:0] task_req;
        logic              flag;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic              faulted;
        logic              kick_allowed;
        logic [CNT_W-1:0]  faults_seen;
        logic [FAIL_W-1:0] failed_task;
        logic [CNT_W-1:0]  good_cycles;
    } t_result;

endpackage

// ===== rtl/core/twpg_in_reg.sv =====
module twpg_in_reg
    import twpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_command,
    input  logic [TASK_W-1:0] i_task_req,
    input  logic              i_flag,
    input  logic              i_adv,
    output logic              o_stall,
    output logic              o_valid,
    output t_item             o_item
);

    logic  r_valid;
    t_item r_item;

    // held item blocks the input only while the core cannot consume it
    assign o_stall = r_valid && !i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item.cmd      <= i_command;
            r_item.task_req <= i_task_req;
            r_item.flag     <= i_flag;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/twpg_core.sv =====
module twpg_core
    import twpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    t_mask             r_enabled, n_enabled;
    t_mask             r_required, n_required;
    t_mask             r_progress, n_progress;
    logic              r_fault, n_fault;
    logic              r_kick, n_kick;
    logic [CNT_W-1:0]  r_faults, n_faults;
    logic [FAIL_W-1:0] r_failed, n_failed;
    logic [CNT_W-1:0]  r_cycles, n_cycles;

    t_mask             bit_sel;
    t_mask             missing;
    logic              in_range;
    logic [FAIL_W-1:0] lowest;
    t_status           status;

    assign in_range = {1'b0, i_item.task_req} < FAIL_W'(TASK_COUNT);
    assign bit_sel  = t_mask'(1) << i_item.task_req;
    assign missing  = r_required & ~r_progress;

    // lowest missing task
    always_comb begin
        lowest = FAIL_NONE;
        for (int i = TASK_COUNT - 1; i >= 0; i--) begin
            if (missing[i]) begin
                lowest = FAIL_W'(i);
            end
        end
    end

    always_comb begin
        n_enabled  = r_enabled;
        n_required = r_required;
        n_progress = r_progress;
        n_fault    = r_fault;
        n_kick     = r_kick;
        n_faults   = r_faults;
        n_failed   = r_failed;
        n_cycles   = r_cycles;
        status     = ST_OK;
        if (i_item.cmd == CMD_CYCLE) begin
            if (r_fault) begin
                n_kick = 1'b0;
                status = ST_FAULT;
            end else if (missing != '0) begin
                n_fault  = 1'b1;
                n_faults = r_faults + CNT_W'(1);
                n_failed = lowest;
                n_kick   = 1'b0;
                status   = ST_FAULT;
            end else begin
                n_cycles   = r_cycles + CNT_W'(1);
                n_kick     = 1'b1;
                n_progress = '0;
            end
        end else if (!in_range) begin
            status = ST_RANGE;
        end else begin
            case (i_item.cmd)
                CMD_MARK: begin
                    if (r_fault) begin
                        status = ST_FAULT;
                    end else if ((r_enabled & bit_sel) == '0) begin
                        status = ST_RANGE;
                    end else begin
                        n_progress = r_progress | bit_sel;
                    end
                end
                CMD_ENABLE: begin
                    if (i_item.flag) begin
                        n_enabled = r_enabled | bit_sel;
                    end else begin
                        n_enabled  = r_enabled & ~bit_sel;
                        n_required = r_required & ~bit_sel;
                        n_progress = r_progress & ~bit_sel;
                    end
                end
                CMD_REQUIRE: begin
                    if (i_item.flag) begin
                        n_enabled  = r_enabled | bit_sel;
                        n_required = r_required | bit_sel;
                    end else begin
                        n_required = r_required & ~bit_sel;
                    end
                end
                CMD_FORCE: begin
                    if (!r_fault) begin
                        n_faults = r_faults + CNT_W'(1);
                        n_failed = FAIL_W'(i_item.task_req);
                    end
                    n_fault = 1'b1;
                    n_kick  = 1'b0;
                end
                default: begin
                    status = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= MASK_RESET;
            r_required <= MASK_RESET;
            r_progress <= '0;
            r_fault    <= 1'b0;
            r_kick     <= 1'b0;
            r_faults   <= '0;
            r_failed   <= FAIL_NONE;
            r_cycles   <= '0;
        end else if (i_fire) begin
            r_enabled  <= n_enabled;
            r_required <= n_required;
            r_progress <= n_progress;
            r_fault    <= n_fault;
            r_kick     <= n_kick;
            r_faults   <= n_faults;
            r_failed   <= n_failed;
            r_cycles   <= n_cycles;
        end
    end

    assign o_result.status       = status;
    assign o_result.faulted      = n_fault;
    assign o_result.kick_allowed = n_kick;
    assign o_result.faults_seen  = n_faults;
    assign o_result.failed_task  = n_failed;
    assign o_result.good_cycles  = n_cycles;

endmodule

// ===== rtl/core/twpg_out_reg.sv =====
module twpg_out_reg
    import twpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_adv,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/task_progress_watchdog_gate.sv =====
// Task progress watchdog gate: every accepted command transaction produces exactly one
// result transaction carrying the status of that command and the supervisor state after it
// (sticky fault, kick permission, fault and good-cycle counters, first failed task). A command
// is latched in an input register, evaluated combinationally against the task masks and
// counters, and the result is captured in an output register whenever that register is
// empty or its held result is taken. One command is taken every clock cycle while the
// output is not stalled; this rate is set by the update of the task masks and counters,
// which each command reads and writes before the next one is evaluated.
module task_progress_watchdog_gate
    import twpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_command,
    input  logic [TASK_W-1:0] i_task_req,
    input  logic              i_flag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic              o_faulted,
    output logic              o_kick_allowed,
    output logic [CNT_W-1:0]  o_faults_seen,
    output logic [FAIL_W-1:0] o_failed_task,
    output logic [CNT_W-1:0]  o_good_cycles
);

    logic    in_valid;
    logic    adv;
    t_item   item;
    t_result result;
    t_result out_result;

    twpg_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_task_req (i_task_req),
        .i_flag     (i_flag),
        .i_adv      (adv),
        .o_stall    (o_stall),
        .o_valid    (in_valid),
        .o_item     (item)
    );

    twpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_valid && adv),
        .i_item   (item),
        .o_result (result)
    );

    twpg_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (result),
        .i_stall  (i_stall),
        .o_adv    (adv),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_status       = out_result.status;
    assign o_faulted      = out_result.faulted;
    assign o_kick_allowed = out_result.kick_allowed;
    assign o_faults_seen  = out_result.faults_seen;
    assign o_failed_task  = out_result.failed_task;
    assign o_good_cycles  = out_result.good_cycles;

endmodule

// ===== rtl/core/twpg_checker.sv =====
module twpg_checker
    import twpg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic              o_faulted,
    input logic              o_kick_allowed,
    input logic [CNT_W-1:0]  o_faults_seen,
    input logic [FAIL_W-1:0] o_failed_task,
    input logic [CNT_W-1:0]  o_good_cycles
);

    // a faulted supervisor never permits a kick
    a_fault_blocks_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_faulted |-> !o_kick_allowed)
        else $error("kick allowed while faulted");

    // fault status only reported once the sticky flag is set
    a_fault_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FAULT) |-> o_faulted)
        else $error("fault status without fault flag");

    // no failed task recorded before the first fault
    a_no_fail_before_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_faulted |-> (o_failed_task == FAIL_NONE) && (o_faults_seen == '0))
        else $error("failure recorded without fault");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_faults_seen)
            && $stable(o_good_cycles) && $stable(o_failed_task))
        else $error("stalled result transaction changed");

endmodule

bind task_progress_watchdog_gate twpg_checker u_twpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_faulted      (o_faulted),
    .o_kick_allowed (o_kick_allowed),
    .o_faults_seen  (o_faults_seen),
    .o_failed_task  (o_failed_task),
    .o_good_cycles  (o_good_cycles)
);
